FILE: rtl/core/http_response_stream_parser_assert.svh
// Assertion macros used by the RTL file that carries assertions.
`ifndef HTTP_RESPONSE_STREAM_PARSER_ASSERT_SVH
`define HTTP_RESPONSE_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HRSP_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrsp assertion failed (same-cycle implication)");

// Next-cycle implication, disabled while reset is high.
`define HRSP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrsp assertion failed (next-cycle implication)");

`endif

FILE: rtl/core/hrsp_pkg.sv
`default_nettype none

package hrsp_pkg;

   localparam int DEF_LINE_COUNT_BITS = 12;
   localparam int DEF_BODY_COUNT_BITS = 31;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int          CL_NAME_LEN = 14;
   localparam int          PROTO_LEN   = 5;
   localparam logic [31:0] VAL_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] VER_MAX     = 32'd255;
   localparam logic [31:0] STATUS_MAX  = 32'd999;

   typedef enum logic [2:0] {
      PH_VERSION = 3'd0,
      PH_STATUS  = 3'd1,
      PH_REASON  = 3'd2,
      PH_HEADERS = 3'd3,
      PH_BODY    = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   typedef enum logic [3:0] {
      EV_NONE        = 4'd0,
      EV_VERSION     = 4'd1,
      EV_STATUS      = 4'd2,
      EV_REASON_END  = 4'd3,
      EV_HEADER      = 4'd4,
      EV_HEADERS_END = 4'd5,
      EV_BODY_BYTE   = 4'd6,
      EV_ERROR       = 4'd7,
      EV_EXTRA       = 4'd8
   } event_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_BAD_VERSION = 3'd1,
      ERR_BAD_STATUS  = 3'd2,
      ERR_BAD_HEADER  = 3'd3,
      ERR_NO_LENGTH   = 3'd4
   } error_type;

   typedef struct packed {
      event_type   event_kind;
      error_type   error_kind;
      logic [7:0]  version_major;
      logic [7:0]  version_minor;
      logic [9:0]  resp_status;
      logic [11:0] text_length;
      logic [11:0] value_length;
      logic        is_content_length;
      logic [30:0] content_length;
      logic [7:0]  data_byte;
      logic        body_last;
      phase_type   phase;
   } rsp_payload_type;

   // Characters of the protocol prefix "HTTP/".
   function automatic logic [7:0] proto_char(input logic [2:0] idx);
      case (idx)
         3'd0:    return 8'h48;
         3'd1:    return 8'h54;
         3'd2:    return 8'h54;
         3'd3:    return 8'h50;
         3'd4:    return 8'h2F;
         default: return 8'h00;
      endcase
   endfunction

   // Lower-case spelling of the Content-Length header name.
   function automatic logic [7:0] cl_char(input logic [3:0] idx);
      case (idx)
         4'd0:    return 8'h63;
         4'd1:    return 8'h6F;
         4'd2:    return 8'h6E;
         4'd3:    return 8'h74;
         4'd4:    return 8'h65;
         4'd5:    return 8'h6E;
         4'd6:    return 8'h74;
         4'd7:    return 8'h2D;
         4'd8:    return 8'h6C;
         4'd9:    return 8'h65;
         4'd10:   return 8'h6E;
         4'd11:   return 8'h67;
         4'd12:   return 8'h74;
         4'd13:   return 8'h68;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   // acc * 10 + digit, clamped to lim. The multiply by ten is two shifts and an add.
   function automatic logic [31:0] sat_digit(input logic [31:0] acc, input logic [7:0] ch,
                                             input logic [31:0] lim);
      logic [35:0] t;
      t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 36'(ch - CH_ZERO);
      return (t > {4'b0, lim}) ? lim : t[31:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hrsp_parser_core.sv
`default_nettype none

module hrsp_parser_core
   import hrsp_pkg::*;
#(
   parameter int LINE_COUNT_BITS = DEF_LINE_COUNT_BITS,
   parameter int BODY_COUNT_BITS = DEF_BODY_COUNT_BITS
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   input  wire logic [7:0]      byte_in,
   input  wire logic            new_response,
   output rsp_payload_type      result
);

   localparam int LCB  = LINE_COUNT_BITS;
   localparam int BCB  = BODY_COUNT_BITS;
   localparam int CapW = (LCB > 12) ? LCB : 12;
   localparam logic [31:0] BodyMax = 32'((64'd1 << BCB) - 64'd1);

   // flags: bit 0 colon seen, bit 1 value started, bit 2 digit run ended.
   typedef struct packed {
      logic [LCB-1:0] lcnt;
      logic [LCB-1:0] kcnt;
      logic [2:0]     flags;
      logic           kmo;
      logic [30:0]    val;
      logic           cr;
   } line_type;

   typedef struct packed {
      phase_type      phase;
      logic [2:0]     prefix;
      logic [7:0]     major;
      logic [7:0]     minor;
      logic [2:0]     dflags;
      logic [9:0]     status;
      line_type       ln;
      logic           len_known;
      logic [BCB-1:0] body_rem;
   } state_type;

   localparam line_type LineClear = '{
      lcnt: '0, kcnt: '0, flags: '0, kmo: 1'b1, val: '0, cr: 1'b0
   };

   localparam state_type StateReset = '{
      phase: PH_VERSION, prefix: '0, major: '0, minor: '0, dflags: '0, status: '0,
      ln: LineClear, len_known: 1'b0, body_rem: '0
   };

   function automatic logic [LCB-1:0] inc_sat(input logic [LCB-1:0] v);
      return (v == {LCB{1'b1}}) ? v : v + LCB'(1);
   endfunction

   function automatic logic [11:0] cap12(input logic [LCB-1:0] v);
      logic [CapW-1:0] w;
      w = CapW'(v);
      return (w > CapW'(12'hFFF)) ? 12'hFFF : w[11:0];
   endfunction

   // One byte of a header line: key up to the colon, then the value.
   function automatic line_type hdr_content(input line_type l, input logic [7:0] ch);
      line_type   r;
      logic [7:0] low;
      r   = l;
      low = ((ch >= 8'h41) && (ch <= 8'h5A)) ? ch + 8'd32 : ch;
      if (!r.flags[0]) begin
         if (ch == CH_COLON) begin
            r.flags[0] = 1'b1;
         end else begin
            if (r.kcnt < LCB'(CL_NAME_LEN)) begin
               if (low != cl_char(r.kcnt[3:0])) r.kmo = 1'b0;
            end else begin
               r.kmo = 1'b0;
            end
            r.kcnt = inc_sat(r.kcnt);
         end
      end else if (r.flags[1] || (ch != CH_SPACE)) begin
         r.flags[1] = 1'b1;
         r.lcnt     = inc_sat(r.lcnt);
         if (!r.flags[2] && is_digit(ch)) begin
            r.val = 31'(sat_digit(32'(r.val), ch, VAL_MAX));
         end else begin
            r.flags[2] = 1'b1;
         end
      end
      return r;
   endfunction

   state_type      state_ff;
   state_type      state_in;
   state_type      cur;
   line_type       hdr_line;
   logic [LCB-1:0] reason_cnt;
   logic [BCB-1:0] body_dec;
   logic [BCB-1:0] body_from_val;
   logic [31:0]    val_wide;
   logic [31:0]    rem_wide;
   logic           is_cl;
   event_type      ev;
   error_type      err;

   assign cur      = new_response ? StateReset : state_ff;
   assign val_wide = {1'b0, cur.ln.val};
   assign rem_wide = 32'(cur.body_rem);
   assign body_from_val = (val_wide > BodyMax) ? BodyMax[BCB-1:0] : val_wide[BCB-1:0];
   assign body_dec = (cur.body_rem != '0) ? cur.body_rem - BCB'(1) : '0;
   assign is_cl    = cur.ln.kmo && (cur.ln.kcnt == LCB'(CL_NAME_LEN));

   always_comb begin
      state_in   = cur;
      result     = '0;
      ev         = EV_NONE;
      err        = ERR_NONE;
      reason_cnt = cur.ln.cr ? inc_sat(cur.ln.lcnt) : cur.ln.lcnt;
      hdr_line   = cur.ln.cr ? hdr_content(cur.ln, CH_CR) : cur.ln;
      hdr_line.cr = 1'b0;

      case (cur.phase)
         PH_VERSION: begin
            if (cur.prefix < 3'(PROTO_LEN)) begin
               if (byte_in == proto_char(cur.prefix)) state_in.prefix = cur.prefix + 3'd1;
               else err = ERR_BAD_VERSION;
            end else if (byte_in == CH_DOT) begin
               state_in.dflags  = {1'b0, cur.ln.lcnt != '0, 1'b1};
               state_in.minor   = '0;
               state_in.ln.lcnt = inc_sat(cur.ln.lcnt);
            end else if (byte_in == CH_SPACE) begin
               if (cur.dflags[2:1] == 2'b11) begin
                  ev                   = EV_VERSION;
                  result.version_major = cur.major;
                  result.version_minor = cur.minor;
                  state_in.phase       = PH_STATUS;
                  state_in.prefix      = '0;
                  state_in.status      = '0;
                  state_in.ln.lcnt     = '0;
               end else begin
                  err = ERR_BAD_VERSION;
               end
            end else if (is_digit(byte_in)) begin
               if (cur.dflags[0]) begin
                  state_in.minor     = 8'(sat_digit(32'(cur.minor), byte_in, VER_MAX));
                  state_in.dflags[2] = 1'b1;
               end else begin
                  state_in.major = 8'(sat_digit(32'(cur.major), byte_in, VER_MAX));
               end
               state_in.ln.lcnt = inc_sat(cur.ln.lcnt);
            end else begin
               err = ERR_BAD_VERSION;
            end
         end
         PH_STATUS: begin
            if (cur.prefix < 3'd3) begin
               if (is_digit(byte_in)) begin
                  state_in.status = 10'(sat_digit(32'(cur.status), byte_in, STATUS_MAX));
                  state_in.prefix = cur.prefix + 3'd1;
               end else begin
                  err = ERR_BAD_STATUS;
               end
            end else if (byte_in == CH_SPACE) begin
               ev                 = EV_STATUS;
               result.resp_status = cur.status;
               state_in.phase     = PH_REASON;
               state_in.ln        = LineClear;
            end else begin
               err = ERR_BAD_STATUS;
            end
         end
         PH_REASON: begin
            if (cur.ln.cr && (byte_in == CH_LF)) begin
               ev                 = EV_REASON_END;
               result.text_length = cap12(cur.ln.lcnt);
               state_in.phase     = PH_HEADERS;
               state_in.ln        = LineClear;
            end else begin
               // A CR opens a line end only once the phrase has a byte.
               state_in.ln.cr   = (byte_in == CH_CR) && (reason_cnt != '0);
               state_in.ln.lcnt = state_in.ln.cr ? reason_cnt : inc_sat(reason_cnt);
            end
         end
         PH_HEADERS: begin
            if (cur.ln.cr && (byte_in == CH_LF)) begin
               if ((cur.ln.kcnt == '0) && (cur.ln.flags == 3'b000)) begin
                  if (!cur.len_known) begin
                     err = ERR_NO_LENGTH;
                  end else begin
                     ev                    = EV_HEADERS_END;
                     result.content_length = rem_wide[30:0];
                     if (cur.body_rem == '0) begin
                        result.body_last = 1'b1;
                        state_in.phase   = PH_DONE;
                     end else begin
                        state_in.phase   = PH_BODY;
                     end
                     state_in.ln = LineClear;
                  end
               end else if (cur.ln.flags[0] && (cur.ln.kcnt != '0) && cur.ln.flags[1]) begin
                  ev                       = EV_HEADER;
                  result.text_length       = cap12(cur.ln.kcnt);
                  result.value_length      = cap12(cur.ln.lcnt);
                  result.is_content_length = is_cl;
                  if (is_cl) begin
                     result.content_length = cur.ln.val;
                     state_in.len_known    = 1'b1;
                     state_in.body_rem     = body_from_val;
                  end
                  state_in.ln = LineClear;
               end else begin
                  err = ERR_BAD_HEADER;
               end
            end else if (byte_in == CH_CR) begin
               state_in.ln    = hdr_line;
               state_in.ln.cr = 1'b1;
            end else begin
               state_in.ln = hdr_content(hdr_line, byte_in);
            end
         end
         PH_BODY: begin
            ev                = EV_BODY_BYTE;
            state_in.body_rem = body_dec;
            if (body_dec == '0) begin
               result.body_last = 1'b1;
               state_in.phase   = PH_DONE;
            end
         end
         default: begin
            ev = EV_EXTRA;
         end
      endcase

      if (err != ERR_NONE) begin
         ev             = EV_ERROR;
         state_in.phase = PH_DONE;
      end

      result.event_kind = ev;
      result.error_kind = err;
      result.data_byte  = byte_in;
      result.phase      = state_in.phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/hrsp_out_reg.sv
`default_nettype none

module hrsp_out_reg
   import hrsp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire rsp_payload_type payload_in,
   output logic                 ready,
   output logic                 valid,
   input  wire logic            take,
   output rsp_payload_type      payload
);

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type payload_ff;

   // The register can take a new result in the same cycle its old one leaves.
   assign ready    = !valid_ff || take;
   assign valid_in = load || (valid_ff && !take);
   assign valid    = valid_ff;
   assign payload  = payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= payload_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/http_response_stream_parser.sv
// HTTP response parser for a byte stream.
// The req_ channel carries one response byte per transaction in req_tdata, with req_tuser
// set on the first byte of a new response to return the parser to the version phase.
// Every accepted byte yields exactly one rsp_ transaction: rsp_tuser gives the event kind
// (version, status, reason end, header, headers end, body byte, error, extra byte),
// rsp_tdata the decoded fields and an echo of the byte, and rsp_tlast marks the final body
// byte or a zero-length body.
// Each result is registered at the edge that accepts its byte. While results are taken,
// throughput is one byte per cycle; the per-byte parser update sits between the parser
// state registers and the result register, and both update on the same accepting edge.
// When the receiver stalls, the result register holds its transaction and req_tready
// drops; it rises again in the cycle the held result is taken, so no bubble is inserted.
// A synchronous reset clears the parser to the version phase and empties the result
// register. After an error or a complete body, bytes are reported as extra until a byte
// arrives with req_tuser set.
`default_nettype none

`include "http_response_stream_parser_assert.svh"

module http_response_stream_parser
   import hrsp_pkg::*;
#(
   parameter int LINE_COUNT_BITS = DEF_LINE_COUNT_BITS,
   parameter int BODY_COUNT_BITS = DEF_BODY_COUNT_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] byte_in
   input  wire logic [0:0]  req_tuser,  // [0] new_response

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] error_kind, [10:3] version_major, [18:11] version_minor, [28:19] resp_status,
   // [40:29] text_length, [52:41] value_length, [53] is_content_length,
   // [84:54] content_length, [92:85] data_byte, [95:93] phase
   output logic [95:0]      rsp_tdata,
   output logic [3:0]       rsp_tuser,  // [3:0] event_kind
   output logic             rsp_tlast   // body_last
);

   logic            req_accept;
   logic            stage_ready;
   rsp_payload_type step_result;
   rsp_payload_type rsp_payload;

   assign req_tready = stage_ready;
   assign req_accept = req_tvalid && stage_ready;

   // Parser state and the per-byte update.
   hrsp_parser_core #(
      .LINE_COUNT_BITS (LINE_COUNT_BITS),
      .BODY_COUNT_BITS (BODY_COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_accept),
      .byte_in      (req_tdata),
      .new_response (req_tuser[0]),
      .result       (step_result)
   );

   // Result register that decouples the two channels.
   hrsp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .payload_in (step_result),
      .ready      (stage_ready),
      .valid      (rsp_tvalid),
      .take       (rsp_tready),
      .payload    (rsp_payload)
   );

   assign rsp_tdata = {
      rsp_payload.phase,
      rsp_payload.data_byte,
      rsp_payload.content_length,
      rsp_payload.is_content_length,
      rsp_payload.value_length,
      rsp_payload.text_length,
      rsp_payload.resp_status,
      rsp_payload.version_minor,
      rsp_payload.version_major,
      rsp_payload.error_kind
   };
   assign rsp_tuser = rsp_payload.event_kind;
   assign rsp_tlast = rsp_payload.body_last;

   // Every accepted byte leaves a result waiting in the next cycle.
   `HRSP_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_accept, rsp_tvalid)

   // An error code travels only with the error event, and always with it.
   `HRSP_ASSERT_IMPL(a_error_code_pairs, clock, reset, rsp_tvalid,
                     (rsp_tuser == EV_ERROR) == (rsp_payload.error_kind != ERR_NONE))

   // The last-byte mark appears only on a body byte or at the end of the headers.
   `HRSP_ASSERT_IMPL(a_last_only_on_body, clock, reset, rsp_tvalid && rsp_tlast,
                     rsp_tuser == EV_BODY_BYTE || rsp_tuser == EV_HEADERS_END)

   // Errors and extra bytes leave the parser in the done phase.
   `HRSP_ASSERT_IMPL(a_error_ends_parse, clock, reset,
                     rsp_tvalid && (rsp_tuser == EV_ERROR || rsp_tuser == EV_EXTRA),
                     rsp_payload.phase == PH_DONE)

endmodule

`default_nettype wire
